// ----- hw/rtl/tcbp_pkg.sv -----
// ----------------------------------------------------------------------------
// tcbp_pkg
// Shared types and codes for the trace-context binary parser.
// ----------------------------------------------------------------------------
package tcbp_pkg;

  localparam int TRACE_ID_BYTES_DEF = 16;
  localparam int SPAN_ID_BYTES_DEF  = 8;

  localparam int PHASE_W = 4;
  localparam int FCNT_W  = 5;
  localparam int LEN_W   = 32;

  // phase codes double as field kinds
  localparam logic [PHASE_W-1:0] PH_TRACE  = 4'd0;
  localparam logic [PHASE_W-1:0] PH_SPAN   = 4'd1;
  localparam logic [PHASE_W-1:0] PH_PARENT = 4'd2;
  localparam logic [PHASE_W-1:0] PH_FLAGS  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_COUNT  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_KEYLEN = 4'd5;
  localparam logic [PHASE_W-1:0] PH_KEY    = 4'd6;
  localparam logic [PHASE_W-1:0] PH_VALLEN = 4'd7;
  localparam logic [PHASE_W-1:0] PH_VALUE  = 4'd8;
  localparam logic [PHASE_W-1:0] PH_EXTRA  = 4'd9;

  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;
  localparam logic [1:0] ST_TRAIL = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } tcbp_in_t;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic [PHASE_W-1:0] field_kind;
    logic               field_end;
    logic               sampled;
    logic [LEN_W-1:0]   pair_index;
    logic [1:0]         status;
  } tcbp_out_t;

endpackage

// ----- hw/rtl/tcbp_core.sv -----
// ----------------------------------------------------------------------------
// tcbp_core
// Parser state and per-byte decode: tags each byte and updates the state
// when an item is taken.
// ----------------------------------------------------------------------------
module tcbp_core #(
  parameter int TRACE_ID_BYTES = tcbp_pkg::TRACE_ID_BYTES_DEF,
  parameter int SPAN_ID_BYTES  = tcbp_pkg::SPAN_ID_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  tcbp_pkg::tcbp_in_t  in_data,
  output tcbp_pkg::tcbp_out_t result
);
  import tcbp_pkg::*;

  localparam logic [FCNT_W:0] TRACE_SIZE = (FCNT_W+1)'(TRACE_ID_BYTES);
  localparam logic [FCNT_W:0] SPAN_SIZE  = (FCNT_W+1)'(SPAN_ID_BYTES);

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [FCNT_W-1:0]  fcnt_r, fcnt_nxt;
  logic [LEN_W-1:0]   len_shift_r, len_shift_nxt;
  logic [LEN_W-1:0]   pairs_left_r, pairs_left_nxt;
  logic [LEN_W-1:0]   pair_cnt_r, pair_cnt_nxt;
  logic [LEN_W-1:0]   bytes_left_r, bytes_left_nxt;
  logic               sampled_r, sampled_nxt;
  logic               extra_r, extra_nxt;

  logic [FCNT_W:0]    fcnt_inc;
  logic [LEN_W-1:0]   len_in;
  logic               len_done;
  logic [LEN_W-1:0]   pairs_dec;
  logic [LEN_W-1:0]   bytes_dec;
  logic [PHASE_W-1:0] kind;
  logic               fend;
  logic [LEN_W-1:0]   pidx;
  logic [1:0]         status;

  assign fcnt_inc  = {1'b0, fcnt_r} + {{FCNT_W{1'b0}}, 1'b1};
  assign len_in    = {len_shift_r[LEN_W-9:0], in_data.in_byte};
  assign len_done  = (fcnt_r >= FCNT_W'(3));
  assign pairs_dec = pairs_left_r - LEN_W'(1);
  assign bytes_dec = bytes_left_r - LEN_W'(1);

  always_comb begin
    phase_nxt      = phase_r;
    fcnt_nxt       = fcnt_r;
    len_shift_nxt  = len_shift_r;
    pairs_left_nxt = pairs_left_r;
    pair_cnt_nxt   = pair_cnt_r;
    bytes_left_nxt = bytes_left_r;
    sampled_nxt    = sampled_r;
    extra_nxt      = extra_r;
    kind           = phase_r;
    fend           = 1'b0;
    pidx           = '0;

    unique case (phase_r)
      PH_TRACE, PH_SPAN, PH_PARENT: begin
        if (fcnt_inc >= ((phase_r == PH_TRACE) ? TRACE_SIZE : SPAN_SIZE)) begin
          fcnt_nxt  = '0;
          fend      = 1'b1;
          phase_nxt = phase_r + PHASE_W'(1);
        end else begin
          fcnt_nxt  = fcnt_inc[FCNT_W-1:0];
        end
      end
      PH_FLAGS: begin
        fend          = 1'b1;
        sampled_nxt   = in_data.in_byte[0];
        fcnt_nxt      = '0;
        len_shift_nxt = '0;
        phase_nxt     = PH_COUNT;
      end
      PH_COUNT, PH_KEYLEN, PH_VALLEN: begin
        if (phase_r != PH_COUNT) begin
          pidx = pair_cnt_r;
        end
        if (len_done) begin
          fend          = 1'b1;
          fcnt_nxt      = '0;
          len_shift_nxt = '0;
          if (phase_r == PH_COUNT) begin
            pairs_left_nxt = len_in;
            phase_nxt      = (len_in == '0) ? PH_EXTRA : PH_KEYLEN;
          end else begin
            bytes_left_nxt = len_in;
            if (phase_r == PH_KEYLEN) begin
              phase_nxt = (len_in == '0) ? PH_VALLEN : PH_KEY;
            end else if (len_in == '0) begin
              // empty value closes the pair
              pairs_left_nxt = pairs_dec;
              pair_cnt_nxt   = pair_cnt_r + LEN_W'(1);
              phase_nxt      = (pairs_dec == '0) ? PH_EXTRA : PH_KEYLEN;
            end else begin
              phase_nxt = PH_VALUE;
            end
          end
        end else begin
          len_shift_nxt = len_in;
          fcnt_nxt      = fcnt_inc[FCNT_W-1:0];
        end
      end
      PH_KEY: begin
        pidx           = pair_cnt_r;
        bytes_left_nxt = bytes_dec;
        if (bytes_dec == '0) begin
          fend      = 1'b1;
          phase_nxt = PH_VALLEN;
        end
      end
      PH_VALUE: begin
        pidx           = pair_cnt_r;
        bytes_left_nxt = bytes_dec;
        if (bytes_dec == '0) begin
          fend           = 1'b1;
          pairs_left_nxt = pairs_dec;
          pair_cnt_nxt   = pair_cnt_r + LEN_W'(1);
          phase_nxt      = (pairs_dec == '0) ? PH_EXTRA : PH_KEYLEN;
        end
      end
      default: begin
        kind      = PH_EXTRA;
        pidx      = pair_cnt_r;
        extra_nxt = 1'b1;
        phase_nxt = PH_EXTRA;
      end
    endcase

    status = ST_BUSY;
    if (in_data.is_last) begin
      if (extra_nxt) begin
        status = ST_TRAIL;
      end else if (phase_nxt == PH_EXTRA) begin
        status = ST_OK;
      end else begin
        status = ST_SHORT;
      end
    end
  end

  assign result.data_byte  = in_data.in_byte;
  assign result.field_kind = kind;
  assign result.field_end  = fend;
  assign result.sampled    = sampled_nxt;
  assign result.pair_index = pidx;
  assign result.status     = status;

  always_ff @(posedge clk) begin
    if (!rst_n || (step && in_data.is_last)) begin
      phase_r      <= PH_TRACE;
      fcnt_r       <= '0;
      len_shift_r  <= '0;
      pairs_left_r <= '0;
      pair_cnt_r   <= '0;
      bytes_left_r <= '0;
      sampled_r    <= 1'b0;
      extra_r      <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      fcnt_r       <= fcnt_nxt;
      len_shift_r  <= len_shift_nxt;
      pairs_left_r <= pairs_left_nxt;
      pair_cnt_r   <= pair_cnt_nxt;
      bytes_left_r <= bytes_left_nxt;
      sampled_r    <= sampled_nxt;
      extra_r      <= extra_nxt;
    end
  end

endmodule

// ----- hw/rtl/tcbp_out_stage.sv -----
// ----------------------------------------------------------------------------
// tcbp_out_stage
// Result register: holds one tagged item until the consumer takes it and
// refills in the same cycle.
// ----------------------------------------------------------------------------
module tcbp_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  tcbp_pkg::tcbp_out_t load_data,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output tcbp_pkg::tcbp_out_t out_data
);
  import tcbp_pkg::*;

  logic      valid_r;
  tcbp_out_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

// ----- hw/rtl/trace_context_binary_parser.sv -----
// A result item appears in the result register in the cycle after its byte is taken.
// Throughput: one byte per cycle while out_ready is high; the result register refills as it drains.
// The state update and byte tag are one pass of decode logic per byte.
// Reset (synchronous, rst_n low) returns the parser to the trace id field
// and empties the result register; a taken is_last byte resets only the parser.
// ----------------------------------------------------------------------------
// trace_context_binary_parser
// Streaming parser for length-prefixed trace-context records.
// ----------------------------------------------------------------------------
module trace_context_binary_parser #(
  parameter int TRACE_ID_BYTES = tcbp_pkg::TRACE_ID_BYTES_DEF,
  parameter int SPAN_ID_BYTES  = tcbp_pkg::SPAN_ID_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcbp_pkg::tcbp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tcbp_pkg::tcbp_out_t out_data
);
  import tcbp_pkg::*;

  logic      take;
  tcbp_out_t result;

  assign take = in_valid && in_ready;

  tcbp_core #(
    .TRACE_ID_BYTES (TRACE_ID_BYTES),
    .SPAN_ID_BYTES  (SPAN_ID_BYTES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (take),
    .in_data (in_data),
    .result  (result)
  );

  tcbp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .load_data (result),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // every taken byte shows up as a result next cycle
  a_take_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid && (out_data.data_byte == $past(in_data.in_byte)))
    else $error("taken item missing from result register");

  // only the final byte carries a verdict
  a_last_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> ((out_data.status != ST_BUSY) == $past(in_data.is_last)))
    else $error("verdict does not match last flag");

  // header bytes belong to no pair
  a_header_pidx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.field_kind == PH_TRACE || out_data.field_kind == PH_SPAN ||
     out_data.field_kind == PH_PARENT || out_data.field_kind == PH_FLAGS ||
     out_data.field_kind == PH_COUNT)) |-> (out_data.pair_index == '0))
    else $error("header byte tagged with nonzero pair index");

endmodule
